[hw/rtl/autoscaled_load_bar_graph_assert.svh]
// Assertion macros used by the bound checker in hw/rtl/albg_checker.sv.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef AUTOSCALED_LOAD_BAR_GRAPH_ASSERT_SVH
`define AUTOSCALED_LOAD_BAR_GRAPH_ASSERT_SVH

// Same-cycle implication.
`define ALBG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("albg assertion failed");

// Next-cycle implication.
`define ALBG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("albg assertion failed");

`endif

[hw/rtl/albg_pkg.sv]
`default_nettype none

package albg_pkg;

    // Sizes
    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int MAX_COLS_LIMIT    = 32;
    localparam int LOAD_W            = 16;
    localparam int COL_W             = 5;
    localparam int CNT_W             = 6;
    localparam int FS_W              = 8;
    localparam int BAR_W             = 8;
    localparam int TOP_W             = 9;
    localparam int STAT_W            = 2;
    localparam int PROD_W            = LOAD_W + FS_W;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int DIV_STEPS         = 16;
    localparam int DIV_CNT_W         = 5;

    // Register reset values
    localparam logic [CNT_W-1:0]  COLS_RST = CNT_W'(19);
    localparam logic [FS_W-1:0]   FS_RST   = FS_W'(24);
    localparam logic [LOAD_W-1:0] LOW_RST  = LOAD_W'(13);
    localparam logic [LOAD_W-1:0] HIGH_RST = LOAD_W'(333);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS   = 2'd0,
        CFG_FULL_SCALE = 2'd1,
        CFG_LOW_THR   = 2'd2,
        CFG_HIGH_THR  = 2'd3
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        ALERT_OFF   = 2'd0,
        ALERT_ON    = 2'd1,
        ALERT_BLINK = 2'd2
    } alert_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_LAST,
        S_SCALE,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [LOAD_W-1:0] new_load;
        logic              sample_valid;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [BAR_W-1:0]  bar_height;
        logic [TOP_W-1:0]  scale_top;
        logic [STAT_W-1:0] alert_status;
        logic              last_column;
    } out_item_t;

    typedef struct packed {
        logic             done;
        logic [BAR_W-1:0] quotient;
    } div_status_t;

endpackage

`default_nettype wire

[hw/rtl/albg_ram.sv]
`default_nettype none

module albg_ram #(
    parameter int WIDTH = albg_pkg::LOAD_W,
    parameter int DEPTH = albg_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/albg_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module albg_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [albg_pkg::LOAD_W-1:0]   dividend,
    input  wire logic [albg_pkg::TOP_W-1:0]    divisor,
    output albg_pkg::div_status_t              status
);

    logic [albg_pkg::TOP_W-1:0]     rem_reg;
    logic [albg_pkg::LOAD_W-1:0]    quo_reg;
    logic [albg_pkg::TOP_W-1:0]     dsr_reg;
    logic [albg_pkg::DIV_CNT_W-1:0] count_reg;
    logic                           done_reg;

    logic [albg_pkg::TOP_W:0]       trial;
    logic                           fits;

    // Trial subtract of the next partial remainder
    assign trial = {rem_reg, quo_reg[albg_pkg::LOAD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                count_reg <= albg_pkg::DIV_CNT_W'(albg_pkg::DIV_STEPS);
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
                done_reg  <= (count_reg == albg_pkg::DIV_CNT_W'(1));
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (count_reg != '0)
        begin
            rem_reg <= fits ? albg_pkg::TOP_W'(trial - {1'b0, dsr_reg})
                            : trial[albg_pkg::TOP_W-1:0];
            quo_reg <= {quo_reg[albg_pkg::LOAD_W-2:0], fits};
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg[albg_pkg::BAR_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/autoscaled_load_bar_graph.sv]
`default_nettype none

// Autoscaled load bar graph. Each accepted transaction carries one 8.8 load
// sample. The block scrolls the sample into the history window, finds the
// window maximum and rounds it up to the scale top. It then delivers one
// result per column, oldest first, with last_column set on the final one.
// in_stall stays high for the whole update after a sample is accepted. The
// update is made of:
//   - a scroll pass over the columns of the dual-port history RAM,
//   - a step to latch the scale top and the status,
//   - per column: one multiply, a 16-step restoring divider and
//     one output load. This part sets the rate.
// Each result held by out_stall lengthens the update.
// in_stall stays high until the last result of the update has been loaded
// into the output register. History entries read as zero until written.
// Per-entry valid flops track this, so no clearing pass is needed after reset.
module autoscaled_load_bar_graph #(
    parameter int HISTORY_DEPTH = albg_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire albg_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output albg_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_wr_en,
    input  wire logic [albg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [albg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW       = $clog2(HISTORY_DEPTH);
    localparam int MAX_COLS = (HISTORY_DEPTH < albg_pkg::MAX_COLS_LIMIT) ?
                              HISTORY_DEPTH : albg_pkg::MAX_COLS_LIMIT;

    // Configuration
    logic [albg_pkg::CNT_W-1:0]  cols_reg;
    logic [albg_pkg::FS_W-1:0]   fs_reg;
    logic [albg_pkg::LOAD_W-1:0] low_reg;
    logic [albg_pkg::LOAD_W-1:0] high_reg;

    // Sequencer and datapath
    albg_pkg::state_t            state_reg;
    albg_pkg::state_t            state_next;
    logic [albg_pkg::LOAD_W-1:0] sample_reg;
    logic                        svalid_reg;
    logic [albg_pkg::CNT_W-1:0]  n_reg;
    logic [albg_pkg::COL_W-1:0]  idx_reg;
    logic [albg_pkg::LOAD_W-1:0] peak_reg;
    logic [albg_pkg::LOAD_W-1:0] newest_reg;
    logic [albg_pkg::TOP_W-1:0]  top_reg;
    albg_pkg::alert_t            status_reg;
    logic [albg_pkg::PROD_W-1:0] prod_reg;
    logic [HISTORY_DEPTH-1:0]    valid_bits_reg;
    logic                        rd_ok_reg;
    logic                        out_valid_reg;
    albg_pkg::out_item_t         out_data_reg;

    // Controls
    logic                        in_accept;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [albg_pkg::LOAD_W-1:0] wr_data;
    logic                        div_start;
    logic                        out_load;

    logic [albg_pkg::CNT_W-1:0]  n_win;
    logic [albg_pkg::COL_W-1:0]  last_idx;
    logic                        last_shift;
    logic                        last_col;
    logic [albg_pkg::LOAD_W-1:0] ram_q;
    logic [albg_pkg::LOAD_W-1:0] rd_val;
    logic [albg_pkg::LOAD_W-1:0] newest_val;
    logic [albg_pkg::LOAD_W:0]   peak_round;
    logic [albg_pkg::TOP_W-1:0]  top_raw;
    logic [albg_pkg::TOP_W-1:0]  top_calc;
    albg_pkg::alert_t            status_calc;
    albg_pkg::div_status_t       div_stat;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= albg_pkg::COLS_RST;
            fs_reg   <= albg_pkg::FS_RST;
            low_reg  <= albg_pkg::LOW_RST;
            high_reg <= albg_pkg::HIGH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (albg_pkg::cfg_reg_t'(cfg_index))
                albg_pkg::CFG_COLUMNS:    cols_reg <= cfg_data[albg_pkg::CNT_W-1:0];
                albg_pkg::CFG_FULL_SCALE: fs_reg   <= cfg_data[albg_pkg::FS_W-1:0];
                albg_pkg::CFG_LOW_THR:    low_reg  <= cfg_data[albg_pkg::LOAD_W-1:0];
                albg_pkg::CFG_HIGH_THR:   high_reg <= cfg_data[albg_pkg::LOAD_W-1:0];
            endcase
        end
    end

    // Effective window size and loop ends
    assign n_win = (cols_reg == '0) ? albg_pkg::CNT_W'(1) :
                   (cols_reg > albg_pkg::CNT_W'(MAX_COLS)) ? albg_pkg::CNT_W'(MAX_COLS) :
                   cols_reg;
    assign last_idx   = albg_pkg::COL_W'(n_reg - 1'b1);
    assign last_shift = ({1'b0, idx_reg} + albg_pkg::CNT_W'(2)) == n_reg;
    assign last_col   = (idx_reg == last_idx);

    assign in_accept  = in_valid && !in_stall;
    assign in_stall   = (state_reg != albg_pkg::S_IDLE);

    // Never-written entries read as zero
    assign rd_val     = rd_ok_reg ? ram_q : '0;
    assign newest_val = svalid_reg ? sample_reg : rd_val;

    // Scale top and alert status
    assign peak_round = {1'b0, peak_reg} + (albg_pkg::LOAD_W + 1)'(255);
    assign top_raw    = peak_round[albg_pkg::LOAD_W:8];
    assign top_calc   = (top_raw == '0) ? albg_pkg::TOP_W'(1) : top_raw;

    always_comb
    begin
        status_calc = albg_pkg::ALERT_ON;
        if (low_reg < high_reg)
        begin
            status_calc = (peak_reg > low_reg) ? albg_pkg::ALERT_ON : albg_pkg::ALERT_OFF;
            if (newest_reg > high_reg)
            begin
                status_calc = albg_pkg::ALERT_BLINK;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            albg_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (n_win == albg_pkg::CNT_W'(1)) ? albg_pkg::S_LAST
                                                                : albg_pkg::S_SHIFT;
                end
            end
            albg_pkg::S_SHIFT:
            begin
                if (last_shift)
                begin
                    state_next = albg_pkg::S_LAST;
                end
            end
            albg_pkg::S_LAST:  state_next = albg_pkg::S_SCALE;
            albg_pkg::S_SCALE: state_next = albg_pkg::S_MUL;
            albg_pkg::S_MUL:   state_next = albg_pkg::S_DIVS;
            albg_pkg::S_DIVS:  state_next = albg_pkg::S_DIVW;
            albg_pkg::S_DIVW:
            begin
                if (div_stat.done)
                begin
                    state_next = albg_pkg::S_OUT;
                end
            end
            albg_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = last_col ? albg_pkg::S_IDLE : albg_pkg::S_MUL;
                end
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = rd_val;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            albg_pkg::S_IDLE:
            begin
                // fetch slot 1, or slot 0 for a one-column window
                rd_en   = in_accept;
                rd_addr = (n_win == albg_pkg::CNT_W'(1)) ? '0 : AW'(1);
            end
            albg_pkg::S_SHIFT:
            begin
                // move slot idx+1 down to idx, fetch the next one
                wr_en   = 1'b1;
                wr_addr = AW'(idx_reg);
                rd_en   = !last_shift;
                rd_addr = AW'({1'b0, idx_reg} + albg_pkg::CNT_W'(2));
            end
            albg_pkg::S_LAST:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(last_idx);
                wr_data = newest_val;
            end
            albg_pkg::S_SCALE:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            albg_pkg::S_MUL:
            begin
            end
            albg_pkg::S_DIVS:
            begin
                div_start = 1'b1;
            end
            albg_pkg::S_DIVW:
            begin
            end
            albg_pkg::S_OUT:
            begin
                out_load = !out_valid_reg || !out_stall;
                rd_en    = out_load && !last_col;
                rd_addr  = AW'({1'b0, idx_reg} + albg_pkg::CNT_W'(1));
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= albg_pkg::S_IDLE;
            valid_bits_reg <= '0;
            rd_ok_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                valid_bits_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_bits_reg[rd_addr];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            albg_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    sample_reg <= in_data.new_load;
                    svalid_reg <= in_data.sample_valid;
                    n_reg      <= n_win;
                    idx_reg    <= '0;
                    peak_reg   <= '0;
                end
            end
            albg_pkg::S_SHIFT:
            begin
                if (rd_val > peak_reg)
                begin
                    peak_reg <= rd_val;
                end
                if (!last_shift)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            albg_pkg::S_LAST:
            begin
                newest_reg <= newest_val;
                if (newest_val > peak_reg)
                begin
                    peak_reg <= newest_val;
                end
            end
            albg_pkg::S_SCALE:
            begin
                top_reg    <= top_calc;
                status_reg <= status_calc;
                idx_reg    <= '0;
            end
            albg_pkg::S_MUL:
            begin
                prod_reg <= albg_pkg::PROD_W'(rd_val) * albg_pkg::PROD_W'(fs_reg);
            end
            albg_pkg::S_DIVS:
            begin
            end
            albg_pkg::S_DIVW:
            begin
            end
            albg_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    idx_reg                   <= idx_reg + 1'b1;
                    out_data_reg.column       <= idx_reg;
                    out_data_reg.bar_height   <= div_stat.quotient;
                    out_data_reg.scale_top    <= top_reg;
                    out_data_reg.alert_status <= status_reg;
                    out_data_reg.last_column  <= last_col;
                end
            end
        endcase
    end

    // History window storage
    albg_ram #(
        .WIDTH (albg_pkg::LOAD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Shared divider: (sample * full_scale >> 8) / scale_top
    albg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[albg_pkg::PROD_W-1:8]),
        .divisor  (top_reg),
        .status   (div_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/albg_checker.sv]
`default_nettype none

`include "autoscaled_load_bar_graph_assert.svh"

module albg_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire albg_pkg::out_item_t out_data
);

    // An accepted sample always starts a multi-cycle update
    `ALBG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // While a non-final column is pending the update is still running
    `ALBG_ASSERT_NOW(a_busy_mid_update, out_valid && !out_data.last_column, in_stall)

    // Hold a stalled result
    `ALBG_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)

    `ALBG_ASSERT_NEXT(a_out_hold_data, out_valid && out_stall, $stable(out_data))

endmodule

bind autoscaled_load_bar_graph albg_checker u_albg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

[tb/sv/albg_checker.sv]
`timescale 1ns / 1ps

module albg_tb_checker #(
    parameter int HISTORY_DEPTH = albg_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  albg_pkg::in_item_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  albg_pkg::out_item_t                 out_data,
    input  logic                                cfg_wr_en,
    input  logic [albg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [albg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  expected_left
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the register file and the load history
    logic [albg_pkg::CNT_W-1:0]  cols_reg;
    logic [albg_pkg::FS_W-1:0]   full_scale_reg;
    logic [albg_pkg::LOAD_W-1:0] low_thr_reg;
    logic [albg_pkg::LOAD_W-1:0] high_thr_reg;
    logic [albg_pkg::LOAD_W-1:0] history [HISTORY_DEPTH];

    // Bars still owed by the block, oldest first
    albg_pkg::out_item_t bars_q [$];

    // Clamp the column count into 1..min(depth, column limit)
    function automatic int unsigned window_width();
        int unsigned width;
        width = cols_reg;
        if (width < 1)
            width = 1;
        if (width > HISTORY_DEPTH)
            width = HISTORY_DEPTH;
        if (width > albg_pkg::MAX_COLS_LIMIT)
            width = albg_pkg::MAX_COLS_LIMIT;
        return width;
    endfunction

    // Scroll one sample into the window and queue the bars it produces
    task automatic predict_bars(input albg_pkg::in_item_t sample);
        int unsigned         width;
        int unsigned         peak;
        int unsigned         top;
        int unsigned         divisor;
        int unsigned         height;
        int unsigned         i;
        albg_pkg::alert_t    status;
        albg_pkg::out_item_t bar;
        width = window_width();
        for (i = 0; i + 1 < width; i++)
            history[i] = history[i + 1];
        if (sample.sample_valid)
            history[width - 1] = sample.new_load;

        peak = 0;
        for (i = 0; i < width; i++)
            if (history[i] > peak)
                peak = history[i];

        top = (peak + 255) >> 8;
        if (top < 1)
            top = 1;
        divisor = top << 8;

        // Status is stuck on unless the thresholds are ordered
        status = albg_pkg::ALERT_ON;
        if (low_thr_reg < high_thr_reg)
        begin
            status = (peak > low_thr_reg) ? albg_pkg::ALERT_ON : albg_pkg::ALERT_OFF;
            if (history[width - 1] > high_thr_reg)
                status = albg_pkg::ALERT_BLINK;
        end

        for (i = 0; i < width; i++)
        begin
            height = (32'(history[i]) * 32'(full_scale_reg)) / divisor;
            bar.column       = albg_pkg::COL_W'(i);
            bar.bar_height   = albg_pkg::BAR_W'(height);
            bar.scale_top    = albg_pkg::TOP_W'(top);
            bar.alert_status = status;
            bar.last_column  = (i + 1 == width);
            bars_q.push_back(bar);
        end
    endtask

    // Compare one delivered bar against the oldest one owed
    task automatic check_bar(input albg_pkg::out_item_t got);
        albg_pkg::out_item_t want;
        if (bars_q.size() == 0)
        begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: bar with nothing owed:", $realtime,
                         " col %0d height %0d top %0d alert %0d last %0d",
                         got.column, got.bar_height, got.scale_top,
                         got.alert_status, got.last_column);
            mismatches++;
        end
        else
        begin
            want = bars_q.pop_front();
            if (got.column !== want.column || got.bar_height !== want.bar_height ||
                got.scale_top !== want.scale_top || got.alert_status !== want.alert_status ||
                got.last_column !== want.last_column)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: bar mismatch:", $realtime,
                             " expected col %0d height %0d top %0d alert %0d last %0d,",
                             want.column, want.bar_height, want.scale_top,
                             want.alert_status, want.last_column,
                             " got col %0d height %0d top %0d alert %0d last %0d",
                             got.column, got.bar_height, got.scale_top,
                             got.alert_status, got.last_column);
                mismatches++;
            end
        end
    endtask

    // Follow register writes and both channels at each accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg       = albg_pkg::COLS_RST;
            full_scale_reg = albg_pkg::FS_RST;
            low_thr_reg    = albg_pkg::LOW_RST;
            high_thr_reg   = albg_pkg::HIGH_RST;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                history[i] = '0;
            bars_q.delete();
            mismatches    = 0;
            expected_left = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    albg_pkg::CFG_COLUMNS:    cols_reg       = cfg_data[albg_pkg::CNT_W-1:0];
                    albg_pkg::CFG_FULL_SCALE: full_scale_reg = cfg_data[albg_pkg::FS_W-1:0];
                    albg_pkg::CFG_LOW_THR:    low_thr_reg    = cfg_data[albg_pkg::LOAD_W-1:0];
                    albg_pkg::CFG_HIGH_THR:   high_thr_reg   = cfg_data[albg_pkg::LOAD_W-1:0];
                    default:                  ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_bars(in_data);
            if (out_valid && !out_stall)
                check_bar(out_data);
            expected_left = bars_q.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 240;
    localparam int IDLE_PERCENT   = 38;
    localparam int DRAIN_CYCLES   = 800;
    localparam int WATCHDOG_LIMIT = 5000;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    albg_pkg::in_item_t              in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    albg_pkg::out_item_t             out_data;
    logic                            cfg_wr_en = 1'b0;
    logic [albg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [albg_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int          mismatches;
    int          expected_left;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    logic [15:0] thr_low  = albg_pkg::LOW_RST;
    logic [15:0] thr_high = albg_pkg::HIGH_RST;

    autoscaled_load_bar_graph dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    albg_tb_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .expected_left (expected_left)
    );

    always #4 clk = ~clk;

    // Stall the bar output at random, except during the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one sample, with an optional gap before it; returns on acceptance
    task automatic send_sample(input logic [15:0] load, input logic valid);
        albg_pkg::in_item_t sample;
        int                 gap;
        sample.new_load     = load;
        sample.sample_valid = valid;
        if (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= sample;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Drop valid and hold until every owed bar has been delivered
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_left != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Write all four registers; unused upper data bits carry junk
    task automatic apply_config(input logic [5:0] cols, input logic [7:0] scale,
                                input logic [15:0] lo, input logic [15:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= albg_pkg::CFG_COLUMNS;
        cfg_data  <= {10'($urandom), cols};
        @(posedge clk);
        cfg_index <= albg_pkg::CFG_FULL_SCALE;
        cfg_data  <= {8'($urandom), scale};
        @(posedge clk);
        cfg_index <= albg_pkg::CFG_LOW_THR;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= albg_pkg::CFG_HIGH_THR;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_low  = lo;
        thr_high = hi;
    endtask

    // Mix extremes, small loads, whole-number edges and threshold edges
    function automatic logic [15:0] pick_load();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3, 4:    return 16'($urandom_range(0, 16'h03FF));
            5:       return {8'($urandom), 8'h00} + 16'($urandom_range(0, 2)) - 16'd1;
            6:       return ($urandom_range(0, 1) ? thr_low : thr_high)
                            + 16'($urandom_range(0, 2)) - 16'd1;
            default: return 16'($urandom_range(0, 16'h1FFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 16'h0600));
    endfunction

    initial
    begin
        int          random_sent;
        int          phase_no;
        int          calm_phase;
        int          burst;
        logic [5:0]  cols;
        logic [7:0]  scale;
        logic [15:0] thr_a;
        logic [15:0] thr_b;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-range samples, a held slot, exact scale top, blink
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0100, 1'b1);
        send_sample(16'h0101, 1'b1);
        send_sample(16'h014E, 1'b1);
        send_sample(16'h000D, 1'b1);
        wait_drained();

        // Single column, widest bars, widest ordered thresholds
        apply_config(6'd1, 8'd255, 16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0001, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h00FF, 1'b0);
        wait_drained();

        // Zero columns act as one, zero full scale, equal thresholds
        apply_config(6'd0, 8'd0, 16'd100, 16'd100);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h0000, 1'b0);
        wait_drained();

        // Oversized column count saturates
        apply_config(6'd63, 8'd255, 16'hFFFE, 16'hFFFF);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFE, 1'b1);
        send_sample(16'h8000, 1'b1);
        wait_drained();

        // Inverted thresholds keep the status on
        apply_config(6'd32, 8'd1, 16'hFFFF, 16'h0000);
        send_sample(16'h5555, 1'b1);
        send_sample(16'hAAAA, 1'b0);
        wait_drained();

        // Newest sample just above and at the high threshold
        apply_config(6'd2, 8'd128, 16'h0000, 16'h0080);
        send_sample(16'h0081, 1'b1);
        send_sample(16'h0080, 1'b1);
        wait_drained();

        // Random settings, each followed by a burst of samples
        random_sent = 0;
        phase_no    = 0;
        calm_phase  = $urandom_range(1, 5);
        while (random_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       cols = 6'd0;
                1:       cols = 6'd1;
                2:       cols = 6'd32;
                3:       cols = 6'($urandom_range(33, 63));
                default: cols = 6'($urandom_range(2, 31));
            endcase
            case ($urandom_range(0, 9))
                0:       scale = 8'd0;
                1:       scale = 8'd255;
                default: scale = 8'($urandom_range(1, 254));
            endcase
            thr_a = pick_threshold();
            thr_b = pick_threshold();
            if ($urandom_range(0, 4) != 0)
                apply_config(cols, scale, (thr_a < thr_b) ? thr_a : thr_b,
                             (thr_a < thr_b) ? thr_b : thr_a);
            else
                apply_config(cols, scale, (thr_a < thr_b) ? thr_b : thr_a,
                             (thr_a < thr_b) ? thr_a : thr_b);

            calm  = (phase_no == calm_phase);
            burst = $urandom_range(8, 30);
            for (int k = 0; k < burst && random_sent < RANDOM_ITEMS; k++)
            begin
                send_sample(pick_load(), $urandom_range(0, 9) < 8);
                random_sent++;
            end
            wait_drained();
            calm = 1'b0;
            phase_no++;
        end

        // Let any stray bars surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_left == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/albg_pkg.sv
hw/rtl/albg_ram.sv
hw/rtl/albg_div.sv
hw/rtl/autoscaled_load_bar_graph.sv
hw/rtl/albg_checker.sv
tb/sv/albg_checker.sv
tb/sv/tb_top.sv
